// ----- rtl/core/tcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // field widths fixed by the interface
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = ATTR_W + CHAR_W;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int PADDR_W = 3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_COLOUR = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_COLOUR, SPACE_CODE};

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_TEXT_COLOUR = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_BLANK
    } tcw_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/tcw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/text_console_writer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Text console, 80x25 cells of {attribute, character}.
// Requests: pulse start while busy is low with func, char_code, read_row and
// read_col; the request is taken at that edge and busy rises for its duration.
// Each request gives exactly one result: done is high for one cycle with
// cell_data and the cursor position after the request. The receiver cannot
// stall; a result must be taken in its cycle.
// Steps from accept: a put of a character or a newline is done from the EXEC
// state; a read passes EXEC and READ (one registered screen memory port); a
// read outside the screen is answered from EXEC; a put that scrolls passes
// EXEC and then BLANK, which blanks the bottom row one cell a cycle.
// Scrolling moves no cells: a top-row offset rotates the rows in the memory.
// Back-to-back, a request may be started in the cycle that done is shown.
// After reset the screen memory is swept to grey-on-black blanks, one cell
// per cycle over all 2000 cells, with busy high; the APB colour register can be
// written at any time, pready is always high.

module text_console_writer_top
    import tcw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               start,
    output logic                    busy,
    input  wire logic               func,
    input  wire logic [CHAR_W-1:0]  char_code,
    input  wire logic [ROW_W-1:0]   read_row,
    input  wire logic [COL_W-1:0]   read_col,

    output logic                    done,
    output logic [CELL_W-1:0]       cell_data,
    output logic [ROW_W-1:0]        cursor_row,
    output logic [COL_W-1:0]        cursor_col,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    tcw_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [ROW_W-1:0]    top_reg, top_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ATTR_W-1:0]   colour_reg;
    logic                func_reg, func_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [ROW_W-1:0]    rrow_reg, rrow_next;
    logic [COL_W-1:0]    rcol_reg, rcol_next;
    logic                done_reg, done_next;
    logic [CELL_W-1:0]   data_reg, data_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [CELL_W-1:0]   ram_rdata;

    logic [ROW_W-1:0]    au_row;
    logic [COL_W-1:0]    au_col;
    logic [ROW_W:0]      au_sum;
    logic [ROW_W-1:0]    au_phys;
    logic [ADDR_W-1:0]   au_addr;

    logic                read_ok;
    logic                is_newline;
    logic                line_end;
    logic                need_scroll;
    logic                clear_last;
    logic                blank_last;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg <= RESET_COLOUR;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_TEXT_COLOUR))
        begin
            colour_reg <= pwdata[ATTR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TEXT_COLOUR)
        begin
            prdata = {{(32-ATTR_W){1'b0}}, colour_reg};
        end
    end

    // ------------------------------------------------- shared address unit
    // logical row plus top-row offset, folded once, times the line length
    always_comb
    begin
        if (state_reg == ST_BLANK)
        begin
            au_row = '0;
            au_col = cnt_reg[COL_W-1:0];
        end
        else if (func_reg == FUNC_READ)
        begin
            au_row = rrow_reg;
            au_col = rcol_reg;
        end
        else
        begin
            au_row = row_reg;
            au_col = col_reg;
        end
        au_sum = {1'b0, au_row} + {1'b0, top_reg};
        if (au_sum >= (ROW_W+1)'(ROWS))
        begin
            au_phys = ROW_W'(au_sum - (ROW_W+1)'(ROWS));
        end
        else
        begin
            au_phys = au_sum[ROW_W-1:0];
        end
        au_addr = ADDR_W'(ADDR_W'(au_phys) * ADDR_W'(COLUMNS)) + ADDR_W'(au_col);
    end

    assign read_ok     = (rrow_reg < ROW_W'(ROWS)) && (rcol_reg < COL_W'(COLUMNS));
    assign is_newline  = (char_reg == NEWLINE_CODE);
    assign line_end    = is_newline || (col_reg == COL_W'(COLUMNS - 1));
    assign need_scroll = line_end && (row_reg == ROW_W'(ROWS - 1));
    assign clear_last  = (cnt_reg == ADDR_W'(CELLS - 1));
    assign blank_last  = (cnt_reg[COL_W-1:0] == COL_W'(COLUMNS - 1));

    // ------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (func_reg == FUNC_READ)
                begin
                    state_next = read_ok ? ST_READ : ST_IDLE;
                end
                else
                begin
                    state_next = need_scroll ? ST_BLANK : ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_BLANK:
            begin
                if (blank_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------- datapath
    always_comb
    begin
        cnt_next  = cnt_reg;
        top_next  = top_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        func_next = func_reg;
        char_next = char_reg;
        rrow_next = rrow_reg;
        rcol_next = rcol_reg;
        data_next = data_reg;
        done_next = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = au_addr;
        ram_wdata = {colour_reg, SPACE_CODE};
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = RESET_CELL;
                cnt_next  = clear_last ? '0 : cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    char_next = char_code;
                    rrow_next = read_row;
                    rcol_next = read_col;
                    cnt_next  = '0;
                end
            end
            ST_EXEC:
            begin
                if (func_reg == FUNC_READ)
                begin
                    // out-of-screen read answers 0 without touching memory
                    if (!read_ok)
                    begin
                        data_next = '0;
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    data_next = '0;
                    if (!is_newline)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {colour_reg, char_reg};
                    end
                    if (line_end)
                    begin
                        col_next = '0;
                        if (!need_scroll)
                        begin
                            row_next  = row_reg + 1'b1;
                            done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        col_next  = col_reg + 1'b1;
                        done_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                data_next = ram_rdata;
                done_next = 1'b1;
            end
            ST_BLANK:
            begin
                // old top row becomes the new bottom row
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (blank_last)
                begin
                    top_next  = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            top_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        char_reg <= char_next;
        rrow_reg <= rrow_next;
        rcol_reg <= rcol_next;
        data_reg <= data_next;
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (au_addr),
        .rdata (ram_rdata)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cell_data  = data_reg;
    assign cursor_row = row_reg;
    assign cursor_col = col_reg;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tcw_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [CELL_W-1:0] data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } console_result_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               func      = FUNC_PUT;
    logic [CHAR_W-1:0]  char_code = '0;
    logic [ROW_W-1:0]   read_row  = '0;
    logic [COL_W-1:0]   read_col  = '0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;

    logic               busy;
    logic               done;
    logic [CELL_W-1:0]  cell_data;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
    logic [31:0]        prdata;
    logic               pready;

    // shadow copy of the console
    logic [CELL_W-1:0]  screen_copy [CELLS];
    int unsigned        cur_row;
    int unsigned        cur_col;
    logic [ATTR_W-1:0]  colour_reg;

    console_result_t    pending_results [$];
    int unsigned        fail_count  = 0;
    int unsigned        cycle_count = 0;
    bit                 idle_on     = 1'b1;

    text_console_writer_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .done       (done),
        .cell_data  (cell_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void advance_row();
        int unsigned i;
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            // scroll: rows move up one, bottom row blanked in current colour
            for (i = 0; i + COLUMNS < CELLS; i++)
                screen_copy[i] = screen_copy[i + COLUMNS];
            for (i = CELLS - COLUMNS; i < CELLS; i++)
                screen_copy[i] = {colour_reg, SPACE_CODE};
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic console_result_t apply_console_request(
        input logic              f,
        input logic [CHAR_W-1:0] ch,
        input logic [ROW_W-1:0]  rr,
        input logic [COL_W-1:0]  rc
    );
        console_result_t res;
        res.data = '0;
        if (f == FUNC_READ)
        begin
            if (int'(rr) < ROWS && int'(rc) < COLUMNS)
                res.data = screen_copy[int'(rr) * COLUMNS + int'(rc)];
        end
        else if (ch == NEWLINE_CODE)
        begin
            advance_row();
        end
        else
        begin
            screen_copy[cur_row * COLUMNS + cur_col] = {colour_reg, ch};
            cur_col++;
            if (cur_col >= COLUMNS)
                advance_row();
        end
        res.row = cur_row[ROW_W-1:0];
        res.col = cur_col[COL_W-1:0];
        return res;
    endfunction

    // result checker; the receiver never stalls
    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: cell_data %h row %0d col %0d",
                       cell_data, cursor_row, cursor_col);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (cell_data !== want.data)
                begin
                    $error("cell_data: expected %h, got %h", want.data, cell_data);
                    fail_count++;
                end
                if (cursor_row !== want.row)
                begin
                    $error("cursor_row: expected %0d, got %0d", want.row, cursor_row);
                    fail_count++;
                end
                if (cursor_col !== want.col)
                begin
                    $error("cursor_col: expected %0d, got %0d", want.col, cursor_col);
                    fail_count++;
                end
            end
        end
    end

    // called at a rising edge; start is left high after the request is taken
    task automatic send_request(
        input logic              f,
        input logic [CHAR_W-1:0] ch,
        input logic [ROW_W-1:0]  rr,
        input logic [COL_W-1:0]  rc
    );
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        func      <= f;
        char_code <= ch;
        read_row  <= rr;
        read_col  <= rc;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_console_request(f, ch, rr, rc));
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_request(FUNC_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic read_cell(input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        send_request(FUNC_READ, CHAR_W'($urandom), rr, rc);
    endtask

    // all results in and the block quiet
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() > 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_TEXT_COLOUR)
            colour_reg = data[ATTR_W-1:0];
    endtask

    task automatic test_directed();
        read_cell('0, '0);
        read_cell(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
        read_cell(ROW_W'(ROWS), '0);           // off the bottom
        read_cell('1, '1);
        read_cell('0, COL_W'(COLUMNS));        // off the right edge
        put_char('0);
        put_char('1);
        put_char("A");
        read_cell('0, COL_W'(0));
        read_cell('0, COL_W'(1));
        read_cell('0, COL_W'(2));
        put_char(NEWLINE_CODE);
        send_request(FUNC_PUT, 8'h55, '1, '1);
        send_request(FUNC_PUT, 8'hAA, '0, '0);
        read_cell(ROW_W'(1), COL_W'(0));
        read_cell(ROW_W'(1), COL_W'(1));
        put_char(NEWLINE_CODE);
        put_char(NEWLINE_CODE);
        read_cell('1, '0);
        read_cell('0, '1);
        read_cell(ROW_W'(3), COL_W'(0));
    endtask

    task automatic test_colour_register();
        wait_idle();
        apb_write(3'd4, 32'hFFFF_FFFF);        // no register there, ignored
        put_char("x");
        read_cell(ROW_W'(3), COL_W'(0));
        wait_idle();
        apb_write(3'd0, 32'h0000_0000);
        put_char("y");
        read_cell(ROW_W'(3), COL_W'(1));
        wait_idle();
        apb_write(3'd0, 32'hFFFF_FF1E);
        put_char("z");
        read_cell(ROW_W'(3), COL_W'(2));
        wait_idle();
        apb_write(3'd0, 32'h0000_00FF);
        put_char(8'h7E);
        read_cell(ROW_W'(3), COL_W'(3));
    endtask

    // fill past the bottom row, then a line long enough to wrap
    task automatic test_wrap_and_scroll();
        int i;
        for (i = 0; i < ROWS + 3; i++)
        begin
            put_char(8'h30 + 8'(i % 10));
            put_char(NEWLINE_CODE);
        end
        read_cell(ROW_W'(ROWS - 1), '0);
        read_cell(ROW_W'(ROWS - 2), '0);
        read_cell('0, '0);
        for (i = 0; i < COLUMNS + 5; i++)
            put_char(CHAR_W'($urandom_range(32, 126)));
        read_cell(ROW_W'(ROWS - 2), COL_W'(COLUMNS - 1));
        read_cell(ROW_W'(ROWS - 1), '0);
        read_cell(ROW_W'(ROWS - 1), COL_W'(5));
    endtask

    task automatic test_random_text(input int count, input int newline_pct);
        int i;
        int unsigned r;
        logic [CHAR_W-1:0] ch;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < newline_pct)
            begin
                put_char(NEWLINE_CODE);
            end
            else if (r < 60)
            begin
                ch = CHAR_W'($urandom);
                if (ch == NEWLINE_CODE)
                    ch = SPACE_CODE;
                put_char(ch);
            end
            else if (r < 75)
            begin
                // near the cursor, where recent writes landed
                read_cell(ROW_W'(cur_row), COL_W'($urandom_range(0, COLUMNS - 1)));
            end
            else if (r < 95)
            begin
                read_cell(ROW_W'($urandom_range(0, ROWS - 1)),
                          COL_W'($urandom_range(0, COLUMNS - 1)));
            end
            else
            begin
                read_cell(ROW_W'($urandom), COL_W'($urandom));
            end
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < CELLS; i++)
            screen_copy[i] = RESET_CELL;
        cur_row    = 0;
        cur_col    = 0;
        colour_reg = RESET_COLOUR;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_colour_register();
        test_wrap_and_scroll();

        wait_idle();
        apb_write(3'd0, 32'h0000_0000);
        test_random_text(200, 10);
        wait_idle();
        apb_write(3'd0, 32'h0000_00FF);
        test_random_text(200, 2);
        wait_idle();
        apb_write(3'd0, $urandom);
        test_random_text(200, 25);
        wait_idle();
        apb_write(3'd4, $urandom);
        apb_write(3'd0, $urandom);
        test_random_text(200, 8);
        wait_idle();
        apb_write(3'd0, 32'(RESET_COLOUR));
        idle_on = 1'b0;
        test_random_text(200, 10);

        wait_idle();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/text_console_writer_top.sv
tb/sv/testbench.sv
